// ===== rtl/core/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the byte stack
// Operation and status codes, sequencer states, sizing of the stack store and its count.
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam int DEPTH   = 16;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 8;
	localparam int KIND_W  = 3;
	localparam int FILL_W  = 5;

	typedef enum logic [KIND_W-1:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_DUP   = 3'd4,
		OP_SWAP  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_TOP,
		S_RD_SEC,
		S_SWAP_WR,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/bsd_cmd_if.sv =====
// ----------------------------------------------------------------------------
// bsd_cmd_if: command channel of the byte stack
// One beat carries an operation kind and the byte to push.
// ----------------------------------------------------------------------------
interface bsd_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [bsd_pkg::KIND_W-1:0]  kind;
	logic [bsd_pkg::DATA_W-1:0]  push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// ===== rtl/core/bsd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bsd_rsp_if: response channel of the byte stack
// One beat carries the byte read, a status and the fill count.
// ----------------------------------------------------------------------------
interface bsd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bsd_pkg::DATA_W-1:0]  read_value;
	logic [1:0]                  status;
	logic [bsd_pkg::FILL_W-1:0]  fill_count;

	modport source (output valid, output read_value, output status, output fill_count,
		input ready);
	modport sink   (input valid, input read_value, input status, input fill_count,
		output ready);
endinterface

// ===== rtl/core/bsd_ram.sv =====
// ----------------------------------------------------------------------------
// bsd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/byte_stack_with_dup_swap.sv =====
// ----------------------------------------------------------------------------
// byte_stack_with_dup_swap: bounded LIFO byte stack with dup and swap
// Stack bytes live in a small RAM; a sequencer reads, modifies, writes back.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : valid/ready beat with kind (push, pop, peek, clear, dup, swap)
//          and push_value. Kinds six and seven are ignored (status ok).
//   rsp  : one beat per command: read_value (top byte of a good pop/peek,
//          else 0), status (ok/underflow/overflow), fill_count after the op.
//   The sequencer goes from IDLE to RD_TOP for pop, peek, dup and swap,
//   then through RD_SEC and SWAP_WR for swap only, and ends in DONE;
//   push, clear, ignored kinds and any failed op go from IDLE straight
//   to DONE.
//   One command is in flight at a time, so a new one is taken only after
//   the previous one has left DONE. The pace is set by the single RAM
//   read port and its registered read data: swap reads two entries, then
//   writes two.
//   The response sits in its own register, so cmd.ready returns as soon as
//   the sequencer is idle even while rsp is stalled; a second finished
//   result waits in the DONE state until the rsp register frees up.
//   Reset clears the count, sequencer and response valid. RAM contents are
//   not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module byte_stack_with_dup_swap (
	input  logic      clk,
	input  logic      arst_n,
	bsd_cmd_if.sink   cmd,
	bsd_rsp_if.source rsp
);

	bsd_pkg::state_t  state_q, state_d;
	logic [bsd_pkg::CNT_W-1:0]  count_q, count_d;
	logic [bsd_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
	logic [bsd_pkg::KIND_W-1:0] kind_q, kind_d;
	bsd_pkg::status_t           st_q, st_d, st_new;
	logic [bsd_pkg::DATA_W-1:0] rd_q, rd_d;
	logic [bsd_pkg::DATA_W-1:0] a_q, a_d;

	// response register
	logic                       rsp_vld_q;
	logic [bsd_pkg::DATA_W-1:0] rsp_rd_q;
	bsd_pkg::status_t           rsp_st_q;
	logic [bsd_pkg::FILL_W-1:0] rsp_fill_q;
	logic                       rsp_load;

	// RAM ports
	logic                        ram_we;
	logic [bsd_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [bsd_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;

	assign cnt_m1 = count_q - bsd_pkg::CNT_W'(1);
	assign cnt_m2 = count_q - bsd_pkg::CNT_W'(2);

	bsd_ram #(
		.WIDTH (bsd_pkg::DATA_W),
		.DEPTH (bsd_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// status of the incoming command against the current count
	always_comb begin
		st_new = bsd_pkg::ST_OK;
		case (cmd.kind)
			bsd_pkg::OP_PUSH: begin
				if (count_q >= bsd_pkg::CNT_W'(bsd_pkg::DEPTH)) st_new = bsd_pkg::ST_OVER;
			end
			bsd_pkg::OP_POP, bsd_pkg::OP_PEEK: begin
				if (count_q == '0) st_new = bsd_pkg::ST_UNDER;
			end
			bsd_pkg::OP_DUP: begin
				if (count_q == '0)
					st_new = bsd_pkg::ST_UNDER;
				else if (count_q >= bsd_pkg::CNT_W'(bsd_pkg::DEPTH))
					st_new = bsd_pkg::ST_OVER;
			end
			bsd_pkg::OP_SWAP: begin
				if (count_q < bsd_pkg::CNT_W'(2)) st_new = bsd_pkg::ST_UNDER;
			end
			default: st_new = bsd_pkg::ST_OK;
		endcase
	end

	// sequencer: next state, datapath updates, RAM control
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		kind_d    = kind_q;
		st_d      = st_q;
		rd_d      = rd_q;
		a_d       = a_q;
		cmd.ready = 1'b0;
		rsp_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[bsd_pkg::ADDR_W-1:0];
		ram_wdata = cmd.push_value;
		ram_raddr = cnt_m1[bsd_pkg::ADDR_W-1:0];

		case (state_q)
			bsd_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					kind_d  = cmd.kind;
					st_d    = st_new;
					rd_d    = '0;
					state_d = bsd_pkg::S_DONE;
					if (st_new == bsd_pkg::ST_OK) begin
						case (cmd.kind)
							bsd_pkg::OP_PUSH: begin
								ram_we  = 1'b1;
								count_d = count_q + bsd_pkg::CNT_W'(1);
							end
							bsd_pkg::OP_CLEAR: count_d = '0;
							bsd_pkg::OP_POP, bsd_pkg::OP_PEEK,
							bsd_pkg::OP_DUP, bsd_pkg::OP_SWAP: state_d = bsd_pkg::S_RD_TOP;
							default: state_d = bsd_pkg::S_DONE;
						endcase
					end
				end
			end
			bsd_pkg::S_RD_TOP: begin
				// top byte arrives from the RAM this cycle
				state_d = bsd_pkg::S_DONE;
				case (kind_q)
					bsd_pkg::OP_POP: begin
						rd_d    = ram_rdata;
						count_d = cnt_m1;
					end
					bsd_pkg::OP_PEEK: rd_d = ram_rdata;
					bsd_pkg::OP_DUP: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata;
						count_d   = count_q + bsd_pkg::CNT_W'(1);
					end
					bsd_pkg::OP_SWAP: begin
						a_d       = ram_rdata;
						ram_raddr = cnt_m2[bsd_pkg::ADDR_W-1:0];
						state_d   = bsd_pkg::S_RD_SEC;
					end
					default: state_d = bsd_pkg::S_DONE;
				endcase
			end
			bsd_pkg::S_RD_SEC: begin
				// second byte goes to the top slot
				ram_we    = 1'b1;
				ram_waddr = cnt_m1[bsd_pkg::ADDR_W-1:0];
				ram_wdata = ram_rdata;
				state_d   = bsd_pkg::S_SWAP_WR;
			end
			bsd_pkg::S_SWAP_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_m2[bsd_pkg::ADDR_W-1:0];
				ram_wdata = a_q;
				state_d   = bsd_pkg::S_DONE;
			end
			bsd_pkg::S_DONE: begin
				if (!rsp_vld_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = bsd_pkg::S_IDLE;
				end
			end
			default: state_d = bsd_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsd_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		st_q   <= st_d;
		rd_q   <= rd_d;
		a_q    <= a_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_rd_q   <= rd_q;
			rsp_st_q   <= st_q;
			rsp_fill_q <= bsd_pkg::FILL_W'(count_q);
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.read_value = rsp_rd_q;
	assign rsp.status     = rsp_st_q;
	assign rsp.fill_count = rsp_fill_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bsd_pkg::CNT_W'(bsd_pkg::DEPTH))
		else $error("stack count beyond depth");

	a_top_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bsd_pkg::S_RD_TOP |-> count_q != '0)
		else $error("top read on empty stack");

	a_swap_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bsd_pkg::S_RD_SEC |-> count_q >= bsd_pkg::CNT_W'(2))
		else $error("swap with fewer than two entries");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && st_q != bsd_pkg::ST_OK |-> rd_q == '0)
		else $error("failed op returns nonzero byte");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> !rsp_vld_q || rsp.ready)
		else $error("response overwritten before taken");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for byte_stack_with_dup_swap
// Drives command beats into the stack and tracks a shadow copy of its
// contents, so that every response beat can be checked field by field. A
// directed part covers the empty and full corner cases. A random walk then
// moves the fill level across the whole range. Both channels idle at random,
// and the response side holds off long enough to stall the command side.
// ----------------------------------------------------------------------------
module testbench;

	// clk period is 8; the slowest correct run is far below this
	localparam int unsigned CYCLE_LIMIT   = 150000;
	// settle margin covers the longest op (swap) plus a parked result
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned RANDOM_ITEMS  = 1800;

	typedef struct packed {
		logic [bsd_pkg::DATA_W-1:0] read_value;
		bsd_pkg::status_t           status;
		logic [bsd_pkg::FILL_W-1:0] fill_count;
	} stack_rsp_t;

	logic clk;
	logic arst_n;

	bsd_cmd_if cmd_ch ();
	bsd_rsp_if rsp_ch ();

	byte_stack_with_dup_swap i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the stack contents and fill level
	logic [bsd_pkg::DATA_W-1:0] shadow_stack [bsd_pkg::DEPTH];
	int unsigned                shadow_count;

	stack_rsp_t  pending_rsps [$];

	// idling control, shared by the tests and the two channel processes
	bit          cmd_steady;
	bit          rsp_steady;
	int unsigned rsp_hold_left;

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned cmds_sent;
	int unsigned rsps_checked;
	int unsigned overflow_seen;
	int unsigned underflow_seen;
	int unsigned full_reached;
	int unsigned swaps_done;

	// ------------------------------------------------------------------------
	// Clock, reset, timeout
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d responses outstanding",
				$time, pending_rsps.size());
			$display("testbench: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Shadow stack: works out the response for one accepted command beat.
	// A failed op leaves the shadow untouched; kinds 6 and 7 fall through to
	// the default and only report the current fill.
	// ------------------------------------------------------------------------
	function automatic stack_rsp_t predict_response(logic [bsd_pkg::KIND_W-1:0] kind,
		logic [bsd_pkg::DATA_W-1:0] value);
		stack_rsp_t                 rsp;
		logic [bsd_pkg::DATA_W-1:0] upper;
		rsp.read_value = '0;
		rsp.status     = bsd_pkg::ST_OK;
		case (kind)
			bsd_pkg::OP_PUSH: begin
				if (shadow_count >= bsd_pkg::DEPTH) begin
					rsp.status = bsd_pkg::ST_OVER;
				end else begin
					shadow_stack[shadow_count] = value;
					shadow_count++;
				end
			end
			bsd_pkg::OP_POP: begin
				if (shadow_count == 0) begin
					rsp.status = bsd_pkg::ST_UNDER;
				end else begin
					rsp.read_value = shadow_stack[shadow_count-1];
					shadow_count--;
				end
			end
			bsd_pkg::OP_PEEK: begin
				if (shadow_count == 0)
					rsp.status = bsd_pkg::ST_UNDER;
				else
					rsp.read_value = shadow_stack[shadow_count-1];
			end
			bsd_pkg::OP_CLEAR: begin
				// bytes stay in place but drop below the count
				shadow_count = 0;
			end
			bsd_pkg::OP_DUP: begin
				if (shadow_count == 0) begin
					rsp.status = bsd_pkg::ST_UNDER;
				end else if (shadow_count >= bsd_pkg::DEPTH) begin
					rsp.status = bsd_pkg::ST_OVER;
				end else begin
					shadow_stack[shadow_count] = shadow_stack[shadow_count-1];
					shadow_count++;
				end
			end
			bsd_pkg::OP_SWAP: begin
				if (shadow_count < 2) begin
					rsp.status = bsd_pkg::ST_UNDER;
				end else begin
					upper = shadow_stack[shadow_count-1];
					shadow_stack[shadow_count-1] = shadow_stack[shadow_count-2];
					shadow_stack[shadow_count-2] = upper;
				end
			end
			default: begin
			end
		endcase
		rsp.fill_count = bsd_pkg::FILL_W'(shadow_count);
		return rsp;
	endfunction

	// ------------------------------------------------------------------------
	// Command side: one beat per call. valid stays high after acceptance so
	// back-to-back beats need no drop; an idle gap lowers it first.
	// ------------------------------------------------------------------------
	task automatic send_op(logic [bsd_pkg::KIND_W-1:0] kind,
		logic [bsd_pkg::DATA_W-1:0] value);
		stack_rsp_t  rsp;
		int unsigned gap;
		if (!cmd_steady && $urandom_range(99) < 15) begin
			gap = $urandom_range(3, 1);
			@(negedge clk) cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.kind       <= kind;
		cmd_ch.push_value <= value;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		rsp = predict_response(kind, value);
		pending_rsps.push_back(rsp);
		cmds_sent++;
		if (rsp.status == bsd_pkg::ST_OVER)
			overflow_seen++;
		if (rsp.status == bsd_pkg::ST_UNDER)
			underflow_seen++;
		if (shadow_count == bsd_pkg::DEPTH)
			full_reached++;
		if (kind == bsd_pkg::OP_SWAP && rsp.status == bsd_pkg::ST_OK)
			swaps_done++;
	endtask

	// Sender pause: drop valid and let every expected response come back,
	// then give the sequencer time to go idle.
	task automatic drain;
		@(negedge clk) cmd_ch.valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: ready is driven on the falling edge. A hold request from
	// a test is counted down here, one cycle at a time.
	// ------------------------------------------------------------------------
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp_ch.ready <= rsp_steady || ($urandom_range(99) >= 15);
			end
		end
	end

	// Every response beat is matched against the oldest expectation.
	always @(posedge clk) begin
		stack_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected response beat: read_value %0d status %0d fill %0d",
					$time, rsp_ch.read_value, rsp_ch.status, rsp_ch.fill_count);
				error_count++;
			end else begin
				want = pending_rsps.pop_front();
				rsps_checked++;
				if (rsp_ch.read_value !== want.read_value) begin
					$display("%0t: read_value mismatch: expected %0d, actual %0d",
						$time, want.read_value, rsp_ch.read_value);
					error_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.fill_count !== want.fill_count) begin
					$display("%0t: fill_count mismatch: expected %0d, actual %0d",
						$time, want.fill_count, rsp_ch.fill_count);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Fresh out of reset: every read-type op must underflow, ignored kinds
	// report an empty stack.
	task automatic test_empty_stack;
		send_op(bsd_pkg::OP_POP, 8'h00);
		send_op(bsd_pkg::OP_PEEK, 8'hFF);
		send_op(bsd_pkg::OP_DUP, 8'h00);
		send_op(bsd_pkg::OP_SWAP, 8'h00);
		send_op(3'd6, 8'hFF);
		send_op(3'd7, 8'h00);
	endtask

	// Extreme bytes, every op on a short stack, swap with exactly one entry.
	task automatic test_short_stack;
		send_op(bsd_pkg::OP_PUSH, 8'h00);
		send_op(bsd_pkg::OP_SWAP, 8'h00);    // one entry only: underflow
		send_op(bsd_pkg::OP_PUSH, 8'hFF);
		send_op(bsd_pkg::OP_SWAP, 8'h00);
		send_op(bsd_pkg::OP_PEEK, 8'h00);    // 0x00 now on top
		send_op(bsd_pkg::OP_DUP, 8'h00);
		send_op(bsd_pkg::OP_PUSH, 8'hAA);
		send_op(bsd_pkg::OP_PUSH, 8'h55);
		send_op(3'd7, 8'hFF);                // ignored, fill unchanged
		send_op(bsd_pkg::OP_POP, 8'h00);
		send_op(bsd_pkg::OP_POP, 8'h00);
		send_op(bsd_pkg::OP_POP, 8'h00);
		send_op(bsd_pkg::OP_CLEAR, 8'h00);
		send_op(bsd_pkg::OP_PEEK, 8'h00);    // cleared: underflow
		send_op(bsd_pkg::OP_CLEAR, 8'h00);   // clear on empty still ok
	endtask

	// Fill to the brim, hit both overflow paths, then empty it again.
	task automatic test_fill_to_full;
		int unsigned i;
		send_op(bsd_pkg::OP_CLEAR, 8'h00);
		send_op(bsd_pkg::OP_PUSH, 8'($urandom_range(255)));
		for (i = 1; i < bsd_pkg::DEPTH; i++)
			send_op(($urandom_range(3) == 0) ? bsd_pkg::OP_DUP : bsd_pkg::OP_PUSH,
				8'($urandom_range(255)));
		send_op(bsd_pkg::OP_PUSH, 8'($urandom_range(255)));
		send_op(bsd_pkg::OP_DUP, 8'h00);
		send_op(bsd_pkg::OP_SWAP, 8'h00);
		send_op(bsd_pkg::OP_PEEK, 8'h00);
		for (i = 0; i < bsd_pkg::DEPTH; i++)
			send_op(bsd_pkg::OP_POP, 8'($urandom_range(255)));
		send_op(bsd_pkg::OP_POP, 8'h00);
	endtask

	// Response side stalls for a long stretch while commands keep coming:
	// the result register and the parked result fill, then cmd.ready drops.
	task automatic test_backpressure;
		int unsigned i;
		cmd_steady    = 1'b1;
		rsp_hold_left = 80;
		for (i = 0; i < 12; i++)
			send_op(($urandom_range(1) == 0) ? bsd_pkg::OP_PUSH : bsd_pkg::OP_SWAP,
				8'($urandom_range(255)));
		cmd_steady = 1'b0;
		drain();
	endtask

	// Picks an op; the mix depends on whether the walk is filling, draining
	// or wandering. A small share is clears and ignored kinds.
	function automatic logic [bsd_pkg::KIND_W-1:0] pick_kind(int unsigned mode);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return ($urandom_range(1) == 0) ? 3'd6 : 3'd7;
		if (r < 5)
			return bsd_pkg::OP_CLEAR;
		case (mode)
			0: begin
				if (r < 55) return bsd_pkg::OP_PUSH;
				if (r < 70) return bsd_pkg::OP_DUP;
				if (r < 80) return bsd_pkg::OP_SWAP;
				if (r < 90) return bsd_pkg::OP_PEEK;
				return bsd_pkg::OP_POP;
			end
			1: begin
				if (r < 20) return bsd_pkg::OP_PUSH;
				if (r < 28) return bsd_pkg::OP_DUP;
				if (r < 38) return bsd_pkg::OP_SWAP;
				if (r < 50) return bsd_pkg::OP_PEEK;
				return bsd_pkg::OP_POP;
			end
			default: begin
				if (r < 35) return bsd_pkg::OP_PUSH;
				if (r < 45) return bsd_pkg::OP_DUP;
				if (r < 60) return bsd_pkg::OP_SWAP;
				if (r < 75) return bsd_pkg::OP_PEEK;
				return bsd_pkg::OP_POP;
			end
		endcase
	endfunction

	// Random walk of the fill level. One window in the middle runs with no
	// idling on either side.
	task automatic test_random_walk(int unsigned n_items);
		int unsigned                done;
		int unsigned                mode;
		logic [bsd_pkg::KIND_W-1:0] kind;
		done = 0;
		mode = 0;
		while (done < n_items) begin
			if (done % 32 == 0)
				mode = $urandom_range(2);
			cmd_steady = (done >= n_items / 3) && (done < n_items / 3 + 300);
			rsp_steady = cmd_steady;
			kind = pick_kind(mode);
			send_op(kind, 8'($urandom_range(255)));
			if (kind <= bsd_pkg::OP_SWAP)
				done++;
		end
		cmd_steady = 1'b0;
		rsp_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.kind       <= bsd_pkg::OP_PUSH;
		cmd_ch.push_value <= '0;
		cmd_steady    = 1'b0;
		rsp_steady    = 1'b0;
		rsp_hold_left = 0;
		shadow_count  = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_stack();
		test_short_stack();
		drain();
		test_fill_to_full();
		test_backpressure();
		test_random_walk(RANDOM_ITEMS);
		drain();

		$display("summary: %0d commands, %0d responses checked, %0d swaps",
			cmds_sent, rsps_checked, swaps_done);
		$display("summary: %0d overflows, %0d underflows, full stack reached %0d times",
			overflow_seen, underflow_seen, full_reached);
		if (error_count == 0 && pending_rsps.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
